[sv/xoshiro256ss_rng_with_mixing_core_assert.svh]
// Assertion macros used by the generator top level.
`ifndef XOSHIRO256SS_RNG_WITH_MIXING_CORE_ASSERT_SVH
`define XOSHIRO256SS_RNG_WITH_MIXING_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define XRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define XRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/xrm_pkg.sv]
// Shared constants, types and helpers for the xoshiro256** generator.
package xrm_pkg;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 64;

   localparam logic [1:0] FUNC_SEED = 2'd0;
   localparam logic [1:0] FUNC_MIX  = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] SM_MUL_A   = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] SM_MUL_B   = 64'h94D049BB133111EB;
   localparam logic [63:0] ACC_A_INIT = 64'h243F6A8885A308D3;
   localparam logic [63:0] ACC_B_INIT = 64'h13198A2E03707344;
   localparam logic [63:0] BYTE_MUL   = 64'hA0761D6478BD642F;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   // rotate left; a zero amount returns the input
   function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
      logic [127:0] dbl;
      dbl = {x, x} << r;
      return dbl[127:64];
   endfunction

endpackage

[sv/xrm_mul.sv]
// Iterative 64x64 low-half multiplier built on one 32x32 partial product unit.
module xrm_mul (
   input  logic                clock,
   input  logic                reset,
   input  xrm_pkg::mul_req_type mul_req,
   output xrm_pkg::mul_rsp_type mul_rsp
);

   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_LH = 2'd1;
   localparam logic [1:0] STEP_HL = 2'd2;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  step_ff, step_in;
   logic [63:0] a_ff, b_ff;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] op_x, op_y;
   logic [63:0] pp;

   // operand select per step: lo*lo, lo*hi, hi*lo
   always_comb begin
      case (step_ff)
         STEP_LL: begin
            op_x = a_ff[31:0];
            op_y = b_ff[31:0];
         end
         STEP_LH: begin
            op_x = a_ff[31:0];
            op_y = b_ff[63:32];
         end
         STEP_HL: begin
            op_x = a_ff[63:32];
            op_y = b_ff[31:0];
         end
         default: begin
            op_x = '0;
            op_y = '0;
         end
      endcase
   end

   assign pp = op_x * op_y;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_LL;
      end else if (busy_ff) begin
         if (step_ff == STEP_LL) begin
            acc_in = pp;
         end else begin
            acc_in = acc_ff + {pp[31:0], 32'b0};
         end
         if (step_ff == STEP_HL) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         step_in = step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         a_ff <= mul_req.a;
         b_ff <= mul_req.b;
      end
      acc_ff <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

[sv/xoshiro256ss_rng_with_mixing_core.sv]
// Top level of the xoshiro256** generator with splitmix64 seeding and byte mixing.
//
//  channel | direction | tdata                                   | tuser     | tlast
//  req_    | in        | seed_value, data_byte, byte_count, pad  | func      | last_byte
//  rsp_    | out       | random_word                             | status    | -
//
//  A read passes ST_RD and ST_RD2 before the result register is loaded; a mix byte
//  waits on one product (then ST_FOLD and ST_ADV when last, for the fold and advance);
//  a seed is built from eight 64-bit products through the shared multiplier.
//  req_tready is high only while the sequencer is idle; one transaction at a time.
//  The result register lets a new transaction be accepted while a read word waits;
//  a later read holds in its final state until that register is free.
//  Reset (synchronous) clears the sequencer, seeded flag and result valid, and loads the accumulators' initial values.

`include "xoshiro256ss_rng_with_mixing_core_assert.svh"

module xoshiro256ss_rng_with_mixing_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [63:0] seed_value, [71:64] data_byte, [75:72] byte_count, [79:76] zero
   input  logic [xrm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] func
   input  logic [xrm_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [63:0] random_word
   output logic [xrm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] status
   output logic                            rsp_tuser
);

   // sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SMA_GO   = 4'd1;
   localparam logic [3:0] ST_SMA_WAIT = 4'd2;
   localparam logic [3:0] ST_SMB_GO   = 4'd3;
   localparam logic [3:0] ST_SMB_WAIT = 4'd4;
   localparam logic [3:0] ST_MIX_GO   = 4'd5;
   localparam logic [3:0] ST_MIX_WAIT = 4'd6;
   localparam logic [3:0] ST_FOLD     = 4'd7;
   localparam logic [3:0] ST_ADV      = 4'd8;
   localparam logic [3:0] ST_RD       = 4'd9;
   localparam logic [3:0] ST_RD2      = 4'd10;
   localparam logic [3:0] ST_RSP      = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic        seeded_ff, seeded_in;
   logic [63:0] acc_a_ff, acc_a_in;
   logic [63:0] acc_b_ff, acc_b_in;
   logic [63:0] gen_ff [4];
   logic [63:0] gen_in [4];
   logic [63:0] sm_ff, sm_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] t_ff, t_in;
   logic [63:0] word_ff, word_in;
   logic        stat_ff, stat_in;
   logic [1:0]  widx_ff, widx_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic        rsp_stat_ff, rsp_stat_in;

   xrm_pkg::mul_req_type mul_req;
   xrm_pkg::mul_rsp_type mul_rsp;

   logic        req_fire;
   logic [1:0]  req_func;
   logic [63:0] adv [4];
   logic [63:0] adv_t;
   logic [63:0] t9;
   logic [3:0]  cnt_sat;
   logic [63:0] byte_mask;
   logic [63:0] sm_z, prod_z, prod_m;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_func   = req_tuser[1:0];

   // one xoshiro256 advance of the current state
   always_comb begin
      adv_t  = gen_ff[1] << 17;
      adv[2] = gen_ff[2] ^ gen_ff[0];
      adv[3] = gen_ff[3] ^ gen_ff[1];
      adv[1] = gen_ff[1] ^ adv[2];
      adv[0] = gen_ff[0] ^ adv[3];
      adv[2] = adv[2] ^ adv_t;
      adv[3] = xrm_pkg::rotl64(adv[3], 6'd45);
   end

   // keep the low bytes that were asked for, saturating at eight
   always_comb begin
      cnt_sat   = (cnt_ff > 4'd8) ? 4'd8 : cnt_ff;
      byte_mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < cnt_sat) begin
            byte_mask[i*8 +: 8] = 8'hFF;
         end
      end
   end

   assign t9     = t_ff + (t_ff << 3);
   assign sm_z   = sm_ff ^ (sm_ff >> 30);
   assign prod_z = mul_rsp.product ^ (mul_rsp.product >> 27);
   assign prod_m = mul_rsp.product ^ (mul_rsp.product >> 31);

   // shared multiplier operands
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = sm_z;
      mul_req.b     = xrm_pkg::SM_MUL_A;
      case (state_ff)
         ST_SMA_GO: begin
            mul_req.start = 1'b1;
         end
         ST_SMB_GO: begin
            mul_req.start = 1'b1;
            mul_req.a     = z_ff;
            mul_req.b     = xrm_pkg::SM_MUL_B;
         end
         ST_MIX_GO: begin
            mul_req.start = 1'b1;
            mul_req.a     = {56'b0, byte_ff};
            mul_req.b     = xrm_pkg::BYTE_MUL;
         end
         default: begin
            mul_req.start = 1'b0;
         end
      endcase
   end

   xrm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      seeded_in    = seeded_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      for (int i = 0; i < 4; i++) begin
         gen_in[i] = gen_ff[i];
      end
      sm_in        = sm_ff;
      z_in         = z_ff;
      t_in         = t_ff;
      word_in      = word_ff;
      stat_in      = stat_ff;
      widx_in      = widx_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               byte_in = req_tdata[71:64];
               last_in = req_tlast;
               cnt_in  = req_tdata[75:72];
               case (req_func)
                  xrm_pkg::FUNC_SEED: begin
                     // a second seed transaction is dropped
                     if (!seeded_ff) begin
                        sm_in    = req_tdata[63:0] + xrm_pkg::GOLDEN_INC;
                        widx_in  = 2'd0;
                        state_in = ST_SMA_GO;
                     end
                  end
                  xrm_pkg::FUNC_MIX: begin
                     if (seeded_ff) begin
                        state_in = ST_MIX_GO;
                     end
                  end
                  xrm_pkg::FUNC_READ: begin
                     word_in  = '0;
                     stat_in  = !seeded_ff;
                     if (seeded_ff && req_tdata[75:72] != 4'd0) begin
                        state_in = ST_RD;
                     end else begin
                        state_in = ST_RSP;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SMA_GO: begin
            state_in = ST_SMA_WAIT;
         end
         ST_SMA_WAIT: begin
            if (mul_rsp.done) begin
               z_in     = prod_z;
               state_in = ST_SMB_GO;
            end
         end
         ST_SMB_GO: begin
            state_in = ST_SMB_WAIT;
         end
         ST_SMB_WAIT: begin
            if (mul_rsp.done) begin
               gen_in[widx_ff] = prod_m;
               if (widx_ff == 2'd3) begin
                  seeded_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  widx_in  = widx_ff + 2'd1;
                  sm_in    = sm_ff + xrm_pkg::GOLDEN_INC;
                  state_in = ST_SMA_GO;
               end
            end
         end
         ST_MIX_GO: begin
            // accumulator A does not wait on the product
            acc_a_in = acc_a_ff ^ ({56'b0, byte_ff} + xrm_pkg::GOLDEN_INC
                                   + (acc_a_ff << 6) + (acc_a_ff >> 2));
            state_in = ST_MIX_WAIT;
         end
         ST_MIX_WAIT: begin
            if (mul_rsp.done) begin
               acc_b_in = acc_b_ff ^ (acc_a_ff
                          + xrm_pkg::rotl64(mul_rsp.product, byte_ff[5:0]));
               state_in = last_ff ? ST_FOLD : ST_IDLE;
            end
         end
         ST_FOLD: begin
            gen_in[0] = gen_ff[0] ^ acc_a_ff;
            gen_in[1] = gen_ff[1] ^ acc_b_ff;
            gen_in[2] = gen_ff[2] ^ xrm_pkg::rotl64(acc_a_ff, 6'd23);
            gen_in[3] = gen_ff[3] ^ xrm_pkg::rotl64(acc_b_ff, 6'd41);
            state_in  = ST_ADV;
         end
         ST_ADV: begin
            for (int i = 0; i < 4; i++) begin
               gen_in[i] = adv[i];
            end
            acc_a_in = xrm_pkg::ACC_A_INIT;
            acc_b_in = xrm_pkg::ACC_B_INIT;
            state_in = ST_IDLE;
         end
         ST_RD: begin
            // scrambler: rotl(s1 * 5, 7), times nine in the next cycle
            t_in = xrm_pkg::rotl64(gen_ff[1] + (gen_ff[1] << 2), 6'd7);
            for (int i = 0; i < 4; i++) begin
               gen_in[i] = adv[i];
            end
            state_in = ST_RD2;
         end
         ST_RD2: begin
            word_in  = t9 & byte_mask;
            state_in = ST_RSP;
         end
         ST_RSP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = word_ff;
               rsp_stat_in  = stat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         acc_a_ff     <= xrm_pkg::ACC_A_INIT;
         acc_b_ff     <= xrm_pkg::ACC_B_INIT;
         rsp_valid_ff <= 1'b0;
         widx_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         acc_a_ff     <= acc_a_in;
         acc_b_ff     <= acc_b_in;
         rsp_valid_ff <= rsp_valid_in;
         widx_ff      <= widx_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         gen_ff[i] <= gen_in[i];
      end
      sm_ff       <= sm_in;
      z_ff        <= z_in;
      t_ff        <= t_in;
      word_ff     <= word_in;
      stat_ff     <= stat_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

   `XRM_ASSERT_NOW(a_mul_done_in_wait, clock, reset, mul_rsp.done, (state_ff == ST_SMA_WAIT || state_ff == ST_SMB_WAIT || state_ff == ST_MIX_WAIT), "product arrived outside a wait state")
   `XRM_ASSERT_NOW(a_unseeded_word_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 64'd0, "unseeded status with non-zero word")
   `XRM_ASSERT_NEXT(a_seeded_sticks, clock, reset, seeded_ff, seeded_ff, "seeded flag dropped")
   `XRM_ASSERT_NEXT(a_reseed_dropped, clock, reset, req_fire && req_func == xrm_pkg::FUNC_SEED && seeded_ff, state_ff == ST_IDLE, "seed transaction not dropped once seeded")

endmodule

[sim/xrm_checker.sv]
// Passive checker for the xoshiro256** generator: predicts read words and compares responses.
module xrm_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // [63:0] seed_value, [71:64] data_byte, [75:72] byte_count, [79:76] zero
   input  logic [xrm_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  logic [xrm_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [63:0] random_word
   input  logic [xrm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] status
   input  logic                           rsp_tuser,
   output int                             mismatches,
   output int                             outstanding,
   output int                             words_seen,
   output int                             folds_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] word;
      logic        status;
   } rng_word_type;

   logic [63:0]  gen_w [4];
   logic [63:0]  acc_a;
   logic [63:0]  acc_b;
   logic         gen_seeded;
   rng_word_type due_words [$];
   int           n_bad;
   int           n_words;
   int           n_folds;

   function automatic logic [63:0] rol(input logic [63:0] x, input int unsigned r);
      int unsigned s;
      s = r % 64;
      if (s == 0) return x;
      return (x << s) | (x >> (64 - s));
   endfunction

   function automatic logic [63:0] splitmix_next(inout logic [63:0] sm);
      logic [63:0] z;
      sm = sm + xrm_pkg::GOLDEN_INC;
      z  = sm;
      z  = (z ^ (z >> 30)) * xrm_pkg::SM_MUL_A;
      z  = (z ^ (z >> 27)) * xrm_pkg::SM_MUL_B;
      return z ^ (z >> 31);
   endfunction

   // one xoshiro256** step on the predicted state; returns the scrambled word
   function automatic logic [63:0] step_state();
      logic [63:0] word_out;
      logic [63:0] t;
      word_out = rol(gen_w[1] * 64'd5, 7) * 64'd9;
      t        = gen_w[1] << 17;
      gen_w[2] = gen_w[2] ^ gen_w[0];
      gen_w[3] = gen_w[3] ^ gen_w[1];
      gen_w[1] = gen_w[1] ^ gen_w[2];
      gen_w[0] = gen_w[0] ^ gen_w[3];
      gen_w[2] = gen_w[2] ^ t;
      gen_w[3] = rol(gen_w[3], 45);
      return word_out;
   endfunction

   always @(posedge clock) begin
      logic [63:0]  sm;
      logic [63:0]  v;
      logic [63:0]  w;
      logic [3:0]   cnt;
      rng_word_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) gen_w[i] = '0;
         acc_a      = xrm_pkg::ACC_A_INIT;
         acc_b      = xrm_pkg::ACC_B_INIT;
         gen_seeded = 1'b0;
         due_words.delete();
         n_bad   = 0;
         n_words = 0;
         n_folds = 0;
      end else begin
         // response side first: a word never belongs to a same-edge request
         if (rsp_tvalid && rsp_tready) begin
            n_words++;
            if (due_words.size() == 0) begin
               if (n_bad < 10)
                  $display("[%0t] unexpected word %h status %b", $realtime, rsp_tdata, rsp_tuser);
               n_bad++;
            end else begin
               want = due_words.pop_front();
               if (rsp_tdata !== want.word || rsp_tuser !== want.status) begin
                  if (n_bad < 10)
                     $display("[%0t] word mismatch: expected %h/%b, got %h/%b", $realtime,
                              want.word, want.status, rsp_tdata, rsp_tuser);
                  n_bad++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            case (req_tuser)
               xrm_pkg::FUNC_SEED: begin
                  if (!gen_seeded) begin
                     sm = req_tdata[63:0];
                     for (int i = 0; i < 4; i++) gen_w[i] = splitmix_next(sm);
                     gen_seeded = 1'b1;
                  end
               end
               xrm_pkg::FUNC_MIX: begin
                  if (gen_seeded) begin
                     v     = {56'd0, req_tdata[71:64]};
                     acc_a = acc_a ^ (v + xrm_pkg::GOLDEN_INC + (acc_a << 6) + (acc_a >> 2));
                     acc_b = acc_b ^ (acc_a + rol(v * xrm_pkg::BYTE_MUL, 32'(v[5:0])));
                     if (req_tlast) begin
                        gen_w[0] = gen_w[0] ^ acc_a;
                        gen_w[1] = gen_w[1] ^ acc_b;
                        gen_w[2] = gen_w[2] ^ rol(acc_a, 23);
                        gen_w[3] = gen_w[3] ^ rol(acc_b, 41);
                        void'(step_state());
                        acc_a = xrm_pkg::ACC_A_INIT;
                        acc_b = xrm_pkg::ACC_B_INIT;
                        n_folds++;
                     end
                  end
               end
               xrm_pkg::FUNC_READ: begin
                  cnt = req_tdata[75:72];
                  if (!gen_seeded) begin
                     due_words.push_back('{word: 64'd0, status: 1'b1});
                  end else if (cnt == 4'd0) begin
                     due_words.push_back('{word: 64'd0, status: 1'b0});
                  end else begin
                     if (cnt > 4'd8) cnt = 4'd8;
                     w = step_state();
                     if (cnt < 4'd8) w = w & ((64'd1 << (cnt * 8)) - 64'd1);
                     due_words.push_back('{word: w, status: 1'b0});
                  end
               end
               default: ;
            endcase
         end
      end
      mismatches  <= n_bad;
      outstanding <= due_words.size();
      words_seen  <= n_words;
      folds_seen  <= n_folds;
   end

endmodule

[sim/testbench.sv]
// Top of the generator testbench: clock, reset, stimulus, response pacing and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // func code 3 is unused by the block and must be ignored
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   localparam int RANDOM_ITEMS = 680;     // mixes and reads in the random part
   localparam int CYCLE_LIMIT  = 300000;  // watchdog limit for the whole run
   localparam int SETTLE       = 100;     // lets a trailing seed finish with margin
   localparam int HOLD_AT      = 60;      // response count at which the long hold starts
   localparam int HOLD_CYCLES  = 400;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [xrm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [xrm_pkg::REQ_USER_W-1:0] req_tuser  = '0;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [xrm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;

   int mismatches;
   int outstanding;
   int words_seen;
   int folds_seen;
   int sent = 0;
   bit tx_idle = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   xoshiro256ss_rng_with_mixing_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   xrm_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .words_seen  (words_seen),
      .folds_seen  (folds_seen)
   );

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one transaction. tvalid is only lowered when a gap is drawn, so it never
   // sees two assignments in one step; the caller returns at the accepting edge.
   task automatic offer(input logic [1:0] func, input logic [63:0] seed,
                        input logic [7:0] dbyte, input logic last, input logic [3:0] count);
      int gap;
      gap = tx_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tlast  <= last;
      req_tdata  <= {4'b0000, count, dbyte, seed};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // unused fields carry noise so the block has to ignore them
   task automatic read_word(input logic [3:0] count);
      offer(xrm_pkg::FUNC_READ, rand64(), 8'($urandom), 1'($urandom), count);
   endtask

   task automatic mix_byte(input logic [7:0] dbyte, input logic last);
      offer(xrm_pkg::FUNC_MIX, rand64(), dbyte, last, 4'($urandom));
   endtask

   task automatic seed_gen(input logic [63:0] value);
      offer(xrm_pkg::FUNC_SEED, value, 8'($urandom), 1'($urandom), 4'($urandom));
   endtask

   // stop offering until every predicted word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Response side: random stalls, quiet stretches, and one long hold-off that
   // backs the block up until req_tready drops.
   initial begin : receiver
      int stall;
      int taken;
      bit rx_idle;
      taken   = 0;
      rx_idle = 1'b1;
      @(posedge clock);
      forever begin
         if (taken % 40 == 0) rx_idle = ($urandom_range(0, 3) != 0);
         if (taken == HOLD_AT) stall = HOLD_CYCLES;
         else stall = rx_idle ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int counted;
      int burst;
      int pick;
      logic [3:0] count;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // before seeding: reads report not-seeded, mixes and the spare code do nothing
      read_word(4'd8);
      read_word(4'd0);
      mix_byte(8'hFF, 1'b1);
      mix_byte(8'h00, 1'b0);
      offer(FUNC_SPARE, rand64(), 8'($urandom), 1'($urandom), 4'($urandom));
      seed_gen(64'hFFFF_FFFF_FFFF_FFFF);
      // a second seed is ignored once seeded
      seed_gen(64'd0);
      read_word(4'd0);        // zero count: empty word, no advance
      read_word(4'd1);
      read_word(4'd8);
      read_word(4'd15);       // saturates to the full word
      read_word(4'd9);
      // a message whose bytes hit rotate-by-zero (0x00, 0x40) and the byte extremes
      mix_byte(8'h00, 1'b0);
      mix_byte(8'hFF, 1'b0);
      mix_byte(8'h3F, 1'b0);
      mix_byte(8'h40, 1'b1);
      read_word(4'd4);
      mix_byte(8'h80, 1'b1);  // single-byte message
      read_word(4'd7);
      offer(FUNC_SPARE, rand64(), 8'($urandom), 1'($urandom), 4'($urandom));
      read_word(4'd2);
      wait_drained();

      // --- random part: mostly mix messages and reads, some noise ---
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted % 50 == 0) tx_idle = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // a message of a few bytes; one in ten runs on without its last marker
            burst = $urandom_range(1, 6);
            for (int k = 0; k < burst; k++)
               mix_byte(8'($urandom), (k == burst - 1) ? ($urandom_range(0, 9) != 0)
                                                       : ($urandom_range(0, 19) == 0));
            counted += burst;
         end else if (pick < 92) begin
            count = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 8));
            read_word(count);
            counted++;
         end else if (pick < 96) begin
            seed_gen(rand64());
         end else begin
            offer(FUNC_SPARE, rand64(), 8'($urandom), 1'($urandom), 4'($urandom));
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);

      $display("Run covered %0d transactions in and %0d words out, with %0d message folds,",
               sent, words_seen, folds_seen);
      $display("reads before seeding, saturated counts, a long response hold and a full drain.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
